/* hdl/aesd_pkg.sv */
// AES-128 decryption package: payload structs, S-box tables and byte helpers.
// Used by every module of the decryption core; depends on nothing else.
package aesd_pkg;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } out_item_t;

  // Key-schedule status passed to the top-level sequencer
  typedef struct packed {
    logic busy;
  } ks_status_t;

  localparam int NumRounds = 10;
  localparam int RndW      = 4;

  // Configuration register indexes
  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;

  // Forward S-box, entry 0 in the top byte
  localparam logic [2047:0] SBOX_V = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  // Inverse S-box, entry 0 in the top byte
  localparam logic [2047:0] INV_SBOX_V = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
  };

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [10:0] base;
    base = {8'hff - x, 3'b000};
    return SBOX_V[base +: 8];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [10:0] base;
    base = {8'hff - x, 3'b000};
    return INV_SBOX_V[base +: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

/* hdl/aes128_block_decrypt_core.sv */
// AES-128 ECB decryption core: top level with round sequencer and result register.
// Depends on aesd_pkg, aesd_key_sched and aesd_round.
//
// Usage:
//  - Input channel in_valid/in_stall/in_data carries a ciphertext block; a transfer
//    happens on a clock edge with in_valid high and in_stall low.
//  - Result channel out_valid/out_stall/out_data carries the plaintext block.
//  - cfg_we/cfg_idx/cfg_wdata writes key_high (index 0) or key_low (index 1).
//    Each write re-expands the key, with in_stall high while it runs.
//  - One block runs from input transfer to result as one round of the
//    shared round unit per cycle for ten rounds, plus the final key add.
//    The round unit is the only datapath, so a new block is taken only once
//    the previous result is in the output register and the sequencer is idle.
//  - Reset (rst_n low, synchronous) clears the keys to zero and then expands the
//    all-zero key, with in_stall high.
//  - While out_stall holds a finished result, the next block may still be
//    taken and decrypted; it waits in the round register until the output frees.
module aes128_block_decrypt_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  aesd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output aesd_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_idx,
  input  logic [63:0]         cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINISH
  } state_t;

  state_t                    state_r, state_nxt;
  logic [aesd_pkg::RndW-1:0] rnd_r, rnd_nxt;
  logic [127:0]              blk_r, blk_nxt;
  logic                      out_valid_r, out_valid_nxt;
  aesd_pkg::out_item_t       out_data_r, out_data_nxt;
  logic [127:0]              rk, round_out;
  aesd_pkg::ks_status_t      ks_status;
  logic                      in_xfer, out_free;

  aesd_key_sched u_key_sched (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .rk_idx    (rnd_r),
    .rk        (rk),
    .status    (ks_status)
  );

  aesd_round u_round (
    .state_in  (blk_r),
    .round_key (rk),
    .mix_en    (rnd_r != aesd_pkg::RndW'(aesd_pkg::NumRounds)),
    .state_out (round_out)
  );

  assign in_stall = (state_r != ST_IDLE) || ks_status.busy;
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Sequence the rounds from key 10 down to key 1, then add key 0
  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    blk_nxt       = blk_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        rnd_nxt = aesd_pkg::RndW'(aesd_pkg::NumRounds);
        if (in_xfer) begin
          blk_nxt   = in_data;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        blk_nxt = round_out;
        rnd_nxt = rnd_r - aesd_pkg::RndW'(1);
        if (rnd_r == aesd_pkg::RndW'(1)) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = blk_r ^ rk;
          rnd_nxt       = aesd_pkg::RndW'(aesd_pkg::NumRounds);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= aesd_pkg::RndW'(aesd_pkg::NumRounds);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    blk_r      <= blk_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Never start a block while the key schedule is still filling the store
  a_no_run_in_expand: assert property (@(posedge clk) disable iff (!rst_n)
    ks_status.busy && state_r == ST_IDLE |=> state_r == ST_IDLE)
    else $error("block started during key expansion");

  // A transfer starts the round sequence at the last round key
  a_start_round: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == ST_ROUND && rnd_r == aesd_pkg::RndW'(aesd_pkg::NumRounds))
    else $error("round sequence did not start");

  // A new result only appears after the final key addition
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FINISH)
    else $error("result without finished block");

endmodule

/* hdl/aesd_key_sched.sv */
// AES-128 key schedule: one round key per cycle into an 11-entry round key store.
// Depends on aesd_pkg for the S-box and xtime.
module aesd_key_sched (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_idx,
  input  logic [63:0]              cfg_wdata,
  input  logic [aesd_pkg::RndW-1:0] rk_idx,
  output logic [127:0]             rk,
  output aesd_pkg::ks_status_t     status
);

  logic [63:0]               key_high_r, key_low_r;
  logic [127:0]              cur_r, cur_nxt;
  logic [aesd_pkg::RndW-1:0] rnd_r, rnd_nxt;
  logic [7:0]                rcon_r, rcon_nxt;
  logic                      busy_r, busy_nxt;
  logic [127:0]              store_r [aesd_pkg::NumRounds+1];
  logic                      wr_en;
  logic [aesd_pkg::RndW-1:0] wr_idx;
  logic [127:0]              wr_data;
  logic [127:0]              new_key, step_key;
  logic [31:0]               w0, w1, w2, w3, t, n0, n1, n2, n3;

  // One schedule step from the current round key
  always_comb begin
    w0 = cur_r[127:96];
    w1 = cur_r[95:64];
    w2 = cur_r[63:32];
    w3 = cur_r[31:0];
    t  = {aesd_pkg::sbox(w3[23:16]) ^ rcon_r, aesd_pkg::sbox(w3[15:8]),
          aesd_pkg::sbox(w3[7:0]), aesd_pkg::sbox(w3[31:24])};
    n0 = w0 ^ t;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
    step_key = {n0, n1, n2, n3};
    new_key  = (cfg_idx == aesd_pkg::CFG_KEY_HIGH) ? {cfg_wdata, key_low_r}
                                                   : {key_high_r, cfg_wdata};
  end

  // Sequence: a key write loads round key 0, then ten steps follow
  always_comb begin
    cur_nxt  = cur_r;
    rnd_nxt  = rnd_r;
    rcon_nxt = rcon_r;
    busy_nxt = busy_r;
    wr_en    = 1'b0;
    wr_idx   = rnd_r;
    wr_data  = step_key;
    if (cfg_we) begin
      cur_nxt  = new_key;
      rnd_nxt  = aesd_pkg::RndW'(1);
      rcon_nxt = 8'h01;
      busy_nxt = 1'b1;
      wr_en    = 1'b1;
      wr_idx   = '0;
      wr_data  = new_key;
    end else if (busy_r) begin
      cur_nxt  = step_key;
      rcon_nxt = aesd_pkg::xtime(rcon_r);
      wr_en    = 1'b1;
      rnd_nxt  = rnd_r + aesd_pkg::RndW'(1);
      if (rnd_r == aesd_pkg::RndW'(aesd_pkg::NumRounds)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      cur_r      <= '0;
      rnd_r      <= aesd_pkg::RndW'(1);
      rcon_r     <= 8'h01;
      busy_r     <= 1'b1;
    end else begin
      if (cfg_we && cfg_idx == aesd_pkg::CFG_KEY_HIGH) key_high_r <= cfg_wdata;
      if (cfg_we && cfg_idx == aesd_pkg::CFG_KEY_LOW)  key_low_r  <= cfg_wdata;
      cur_r  <= cur_nxt;
      rnd_r  <= rnd_nxt;
      rcon_r <= rcon_nxt;
      busy_r <= busy_nxt;
    end
  end

  // Round key store; reset seeds round key 0 with the all-zero key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r[0] <= '0;
    end else if (wr_en) begin
      store_r[wr_idx] <= wr_data;
    end
  end

  assign rk          = store_r[rk_idx];
  assign status.busy = busy_r;

endmodule

/* hdl/aesd_round.sv */
// AES-128 inverse round unit: AddRoundKey, optional InvMixColumns, InvShiftRows, InvSubBytes.
// Depends on aesd_pkg for the inverse S-box and xtime.
module aesd_round (
  input  logic [127:0] state_in,
  input  logic [127:0] round_key,
  input  logic         mix_en,
  output logic [127:0] state_out
);

  logic [7:0] a [16];
  logic [7:0] m [16];
  logic [7:0] x2, x4, x8;
  logic [7:0] p9 [16], pb [16], pd [16], pe [16];

  always_comb begin
    // Add the round key, then take byte multiples for the column mix
    for (int n = 0; n < 16; n++) begin
      a[n]  = state_in[127-8*n -: 8] ^ round_key[127-8*n -: 8];
      x2    = aesd_pkg::xtime(a[n]);
      x4    = aesd_pkg::xtime(x2);
      x8    = aesd_pkg::xtime(x4);
      p9[n] = x8 ^ a[n];
      pb[n] = x8 ^ x2 ^ a[n];
      pd[n] = x8 ^ x4 ^ a[n];
      pe[n] = x8 ^ x4 ^ x2;
    end
    // Mix each column, or pass through on the first round
    for (int c = 0; c < 4; c++) begin
      if (mix_en) begin
        m[4*c]   = pe[4*c] ^ pb[4*c+1] ^ pd[4*c+2] ^ p9[4*c+3];
        m[4*c+1] = p9[4*c] ^ pe[4*c+1] ^ pb[4*c+2] ^ pd[4*c+3];
        m[4*c+2] = pd[4*c] ^ p9[4*c+1] ^ pe[4*c+2] ^ pb[4*c+3];
        m[4*c+3] = pb[4*c] ^ pd[4*c+1] ^ p9[4*c+2] ^ pe[4*c+3];
      end else begin
        m[4*c]   = a[4*c];
        m[4*c+1] = a[4*c+1];
        m[4*c+2] = a[4*c+2];
        m[4*c+3] = a[4*c+3];
      end
    end
    // Inverse row shift with inverse substitution
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        state_out[127-8*(4*c+r) -: 8] = aesd_pkg::inv_sbox(m[4*((c-r+4)%4)+r]);
      end
    end
  end

endmodule
